// File: rtl/command_packet_framer_assert.svh
// Assertion macros for the command packet framer.
// Used by the top level only; no other dependencies.
`ifndef COMMAND_PACKET_FRAMER_ASSERT_SVH
`define COMMAND_PACKET_FRAMER_ASSERT_SVH

// same-cycle implication
`define CPF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("command_packet_framer: same-cycle check failed");

// next-cycle implication
`define CPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("command_packet_framer: next-cycle check failed");

`endif

// File: rtl/cpf_pkg.sv
// Shared types and constants for the command packet framer.
// No dependencies.
package cpf_pkg;

   localparam int unsigned BURST_MAX     = 8;
   localparam int unsigned BURST_COUNT_W = 4;

   localparam logic OP_HEADER = 1'b0;
   localparam logic OP_DATA   = 1'b1;

   localparam logic CSR_SYNC_FIRST  = 1'b0;
   localparam logic CSR_SYNC_SECOND = 1'b1;

   localparam logic [7:0] SYNC_FIRST_RESET  = 8'hF5;
   localparam logic [7:0] SYNC_SECOND_RESET = 8'hFA;

   typedef struct packed {
      logic [BURST_MAX-1:0][7:0]  data;
      logic [BURST_COUNT_W-1:0]   count;
      logic                       close;
   } burst_type;

endpackage

// File: rtl/cpf_frame.sv
// Framing state: byte count, running sum and burst formation per accepted beat.
// Depends on cpf_pkg.
module cpf_frame (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   op,
   input  logic [7:0]             pid_one,
   input  logic [7:0]             pid_two,
   input  logic [15:0]            payload_length,
   input  logic [7:0]             payload_byte,
   input  logic [7:0]             sync_first,
   input  logic [7:0]             sync_second,
   output cpf_pkg::burst_type     burst
);

   logic [15:0] bytes_remaining_ff, bytes_remaining_in;
   logic [15:0] running_sum_ff, running_sum_in;
   logic        in_packet_ff, in_packet_in;

   logic [15:0] header_sum;
   logic [15:0] header_check;
   logic [15:0] data_sum;
   logic [15:0] data_check;
   logic [15:0] remaining_dec;

   assign header_sum = {8'h00, sync_first} + {8'h00, sync_second}
                     + {8'h00, pid_one} + {8'h00, pid_two}
                     + {8'h00, payload_length[15:8]} + {8'h00, payload_length[7:0]};
   assign header_check  = (header_sum ^ 16'hFFFF) + 16'h0001;
   assign data_sum      = running_sum_ff + {8'h00, payload_byte};
   assign data_check    = (data_sum ^ 16'hFFFF) + 16'h0001;
   assign remaining_dec = bytes_remaining_ff - 16'h0001;

   always_comb begin
      bytes_remaining_in = bytes_remaining_ff;
      running_sum_in     = running_sum_ff;
      in_packet_in       = in_packet_ff;
      burst              = '0;
      case (op)
         cpf_pkg::OP_HEADER: begin
            burst.data[0] = sync_first;
            burst.data[1] = sync_second;
            burst.data[2] = pid_one;
            burst.data[3] = pid_two;
            burst.data[4] = payload_length[15:8];
            burst.data[5] = payload_length[7:0];
            if (payload_length == 16'h0000) begin
               burst.data[6]      = header_check[15:8];
               burst.data[7]      = header_check[7:0];
               burst.count        = cpf_pkg::BURST_COUNT_W'(8);
               burst.close        = 1'b1;
               bytes_remaining_in = 16'h0000;
               running_sum_in     = 16'h0000;
               in_packet_in       = 1'b0;
            end else begin
               burst.count        = cpf_pkg::BURST_COUNT_W'(6);
               bytes_remaining_in = payload_length;
               running_sum_in     = header_sum;
               in_packet_in       = 1'b1;
            end
         end
         cpf_pkg::OP_DATA: begin
            if (in_packet_ff && (bytes_remaining_ff != 16'h0000)) begin
               burst.data[0] = payload_byte;
               if (remaining_dec == 16'h0000) begin
                  burst.data[1]      = data_check[15:8];
                  burst.data[2]      = data_check[7:0];
                  burst.count        = cpf_pkg::BURST_COUNT_W'(3);
                  burst.close        = 1'b1;
                  bytes_remaining_in = 16'h0000;
                  running_sum_in     = 16'h0000;
                  in_packet_in       = 1'b0;
               end else begin
                  burst.count        = cpf_pkg::BURST_COUNT_W'(1);
                  bytes_remaining_in = remaining_dec;
                  running_sum_in     = data_sum;
               end
            end
         end
         default: begin
            burst = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_remaining_ff <= 16'h0000;
         running_sum_ff     <= 16'h0000;
         in_packet_ff       <= 1'b0;
      end else if (accept) begin
         bytes_remaining_ff <= bytes_remaining_in;
         running_sum_ff     <= running_sum_in;
         in_packet_ff       <= in_packet_in;
      end
   end

endmodule

// File: rtl/cpf_burst.sv
// Output shift register: holds the bytes of one beat and sends them one per beat.
// Depends on cpf_pkg.
module cpf_burst (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  cpf_pkg::burst_type  burst,
   input  logic                rsp_stall,
   output logic                busy,
   output logic                rsp_valid,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_end_of_packet
);

   logic [cpf_pkg::BURST_MAX-1:0][7:0]   data_ff, data_in;
   logic [cpf_pkg::BURST_COUNT_W-1:0]    count_ff, count_in;
   logic                                 close_ff, close_in;
   logic                                 take;
   logic                                 last;

   assign rsp_valid         = (count_ff != '0);
   assign take              = rsp_valid && !rsp_stall;
   assign last              = (count_ff == cpf_pkg::BURST_COUNT_W'(1));
   assign busy              = rsp_valid && !(last && take);
   assign rsp_out_byte      = data_ff[0];
   assign rsp_end_of_packet = last && close_ff;

   always_comb begin
      data_in  = data_ff;
      count_in = count_ff;
      close_in = close_ff;
      if (load) begin
         data_in  = burst.data;
         count_in = burst.count;
         close_in = burst.close;
      end else if (take) begin
         data_in  = data_ff >> 8;
         count_in = count_ff - cpf_pkg::BURST_COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         close_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         close_ff <= close_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// File: rtl/command_packet_framer.sv
// Command packet framer top level: sync registers, framing state and output.
// Depends on cpf_pkg, cpf_frame, cpf_burst and command_packet_framer_assert.svh.
//
// Turns header and payload beats into a framed byte stream, one byte per rsp
// beat. A payload beat in an open packet gives one byte and is taken every
// cycle while the output flows; the last payload beat gives three bytes
// (byte and checksum). A header gives six bytes, or eight with a zero length,
// so the next req beat waits until the output shift register has sent all but
// its final byte, and the following beat is taken in the cycle the final
// byte goes out.
`include "command_packet_framer_assert.svh"

module command_packet_framer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [7:0]  req_pid_one,
   input  logic [7:0]  req_pid_two,
   input  logic [15:0] req_payload_length,
   input  logic [7:0]  req_payload_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_end_of_packet,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [7:0]  csr_write_data
);

   logic [7:0]          sync_first_ff;
   logic [7:0]          sync_second_ff;
   logic                accept;
   logic                busy;
   logic                header_take;
   logic                eop_take;
   cpf_pkg::burst_type  burst;

   assign req_stall   = busy;
   assign accept      = req_valid && !busy;
   assign header_take = accept && (req_op == cpf_pkg::OP_HEADER);
   assign eop_take    = rsp_valid && !rsp_stall && rsp_end_of_packet;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= cpf_pkg::SYNC_FIRST_RESET;
         sync_second_ff <= cpf_pkg::SYNC_SECOND_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            cpf_pkg::CSR_SYNC_FIRST:  sync_first_ff  <= csr_write_data;
            cpf_pkg::CSR_SYNC_SECOND: sync_second_ff <= csr_write_data;
            default: begin
               sync_first_ff <= sync_first_ff;
            end
         endcase
      end
   end

   cpf_frame u_frame (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .op             (req_op),
      .pid_one        (req_pid_one),
      .pid_two        (req_pid_two),
      .payload_length (req_payload_length),
      .payload_byte   (req_payload_byte),
      .sync_first     (sync_first_ff),
      .sync_second    (sync_second_ff),
      .burst          (burst)
   );

   cpf_burst u_burst (
      .clock             (clock),
      .reset             (reset),
      .load              (accept),
      .burst             (burst),
      .rsp_stall         (rsp_stall),
      .busy              (busy),
      .rsp_valid         (rsp_valid),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_packet (rsp_end_of_packet)
   );

   `CPF_ASSERT_SAME(a_stall_needs_output, clock, reset, req_stall, rsp_valid)
   `CPF_ASSERT_NEXT(a_header_opens_with_sync, clock, reset, header_take,
                    rsp_valid && (rsp_out_byte == $past(sync_first_ff)))
   `CPF_ASSERT_NEXT(a_eop_ends_burst, clock, reset, eop_take, $past(accept) || !rsp_valid)

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Testbench for command_packet_framer: drives header and payload beats with random gaps and
// stalls, predicts the framed byte stream with checksum and checks every rsp beat in order.
// Depends on cpf_pkg and the command_packet_framer RTL.

module tb;

   localparam int DRAIN_PAUSE            = 16;
   localparam int RANDOM_BEATS_PER_PHASE = 72;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_op;
   logic [7:0]  req_pid_one;
   logic [7:0]  req_pid_two;
   logic [15:0] req_payload_length;
   logic [7:0]  req_payload_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_byte;
   logic        rsp_end_of_packet;
   logic        csr_write_enable;
   logic        csr_index;
   logic [7:0]  csr_write_data;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } frame_byte_type;

   frame_byte_type frame_bytes[$];
   frame_byte_type wanted_byte;

   logic [7:0]  model_sync_first;
   logic [7:0]  model_sync_second;
   logic [15:0] model_remaining;
   logic [15:0] model_sum;
   logic        model_in_packet;

   int send_idle_pct;
   int recv_idle_pct;
   int errors;
   int beats_sent;
   int framed_beats;
   int bytes_checked;
   int packets_started;
   int sync_writes;

   command_packet_framer u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_pid_one        (req_pid_one),
      .req_pid_two        (req_pid_two),
      .req_payload_length (req_payload_length),
      .req_payload_byte   (req_payload_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_end_of_packet  (rsp_end_of_packet),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_bytes.size() == 0) begin
            errors++;
            $display("%0t: rsp beat with nothing expected, got byte %02h end %0b",
                     $time, rsp_out_byte, rsp_end_of_packet);
         end else begin
            wanted_byte = frame_bytes.pop_front();
            bytes_checked++;
            if (rsp_out_byte !== wanted_byte.value) begin
               errors++;
               $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                        $time, wanted_byte.value, rsp_out_byte);
            end
            if (rsp_end_of_packet !== wanted_byte.last) begin
               errors++;
               $display("%0t: end_of_packet mismatch, expected %0b, actual %0b",
                        $time, wanted_byte.last, rsp_end_of_packet);
            end
         end
      end
   end

   task automatic push_frame_byte(input logic [7:0] b, input logic last);
      frame_bytes.push_back('{value: b, last: last});
      model_sum = model_sum + 16'(b);
   endtask

   task automatic push_checksum();
      logic [15:0] checksum;
      checksum = ~model_sum + 16'd1;
      push_frame_byte(checksum[15:8], 1'b0);
      push_frame_byte(checksum[7:0], 1'b1);
      model_in_packet = 1'b0;
      model_remaining = 16'd0;
      model_sum       = 16'd0;
   endtask

   task automatic predict_frame(input logic op, input logic [7:0] pid_one,
                                input logic [7:0] pid_two, input logic [15:0] length,
                                input logic [7:0] payload);
      if (op == cpf_pkg::OP_HEADER) begin
         model_sum = 16'd0;
         packets_started++;
         framed_beats++;
         push_frame_byte(model_sync_first, 1'b0);
         push_frame_byte(model_sync_second, 1'b0);
         push_frame_byte(pid_one, 1'b0);
         push_frame_byte(pid_two, 1'b0);
         push_frame_byte(length[15:8], 1'b0);
         push_frame_byte(length[7:0], 1'b0);
         if (length == 16'd0) begin
            push_checksum();
         end else begin
            model_remaining = length;
            model_in_packet = 1'b1;
         end
      end else if (model_in_packet && model_remaining != 16'd0) begin
         framed_beats++;
         push_frame_byte(payload, 1'b0);
         model_remaining = model_remaining - 16'd1;
         if (model_remaining == 16'd0) begin
            push_checksum();
         end
      end
   endtask

   task automatic send_beat(input logic op, input logic [7:0] pid_one,
                            input logic [7:0] pid_two, input logic [15:0] length,
                            input logic [7:0] payload);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid          <= 1'b0;
         req_op             <= 1'($urandom);
         req_pid_one        <= 8'($urandom);
         req_pid_two        <= 8'($urandom);
         req_payload_length <= 16'($urandom);
         req_payload_byte   <= 8'($urandom);
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_op             <= op;
      req_pid_one        <= pid_one;
      req_pid_two        <= pid_two;
      req_payload_length <= length;
      req_payload_byte   <= payload;
      do @(posedge clock); while (req_stall);
      beats_sent++;
      predict_frame(op, pid_one, pid_two, length, payload);
   endtask

   task automatic send_header(input logic [7:0] pid_one, input logic [7:0] pid_two,
                              input logic [15:0] length);
      send_beat(cpf_pkg::OP_HEADER, pid_one, pid_two, length, 8'($urandom));
   endtask

   task automatic send_data(input logic [7:0] payload);
      send_beat(cpf_pkg::OP_DATA, 8'($urandom), 8'($urandom), 16'($urandom), payload);
   endtask

   task automatic drain_frames();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frame_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   task automatic write_sync(input logic index, input logic [7:0] data);
      drain_frames();
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == cpf_pkg::CSR_SYNC_FIRST) begin
         model_sync_first = data;
      end else begin
         model_sync_second = data;
      end
      sync_writes++;
      @(posedge clock);
   endtask

   task automatic send_random_packet();
      int pick;
      int length;
      int count;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         length = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
         send_header(8'($urandom), 8'($urandom), 16'(length));
         repeat (length) send_data(8'($urandom));
      end else if (pick < 85) begin
         // open a packet and abandon it part way
         length = $urandom_range(1, 65535);
         count  = $urandom_range(0, (length < 6) ? length - 1 : 5);
         send_header(8'($urandom), 8'($urandom), 16'(length));
         repeat (count) send_data(8'($urandom));
      end else begin
         repeat ($urandom_range(1, 3)) send_data(8'($urandom));
      end
   endtask

   task automatic test_idle_data_and_empty_packet();
      send_data(8'h3C);
      send_data(8'hC3);
      send_header(8'h00, 8'h00, 16'h0000);
      send_data(8'hFF);
      drain_frames();
   endtask

   task automatic test_field_extremes_and_restart();
      send_header(8'hFF, 8'hFF, 16'hFFFF);
      send_data(8'hFF);
      send_data(8'h00);
      send_header(8'hA5, 8'h5A, 16'h0001);
      send_data(8'h80);
      send_header(8'h5A, 8'hA5, 16'h8000);
      send_data(8'h7F);
      send_header(8'h01, 8'h80, 16'h0002);
      send_data(8'h01);
      send_data(8'hFE);
      send_data(8'h55);
      drain_frames();
   endtask

   task automatic test_sync_registers();
      write_sync(cpf_pkg::CSR_SYNC_FIRST, 8'h00);
      write_sync(cpf_pkg::CSR_SYNC_SECOND, 8'hFF);
      send_header(8'h10, 8'h20, 16'h0000);
      write_sync(cpf_pkg::CSR_SYNC_FIRST, 8'hFF);
      write_sync(cpf_pkg::CSR_SYNC_SECOND, 8'h00);
      send_header(8'h30, 8'h40, 16'h0003);
      send_data(8'h11);
      // change both syncs while the packet is still open
      write_sync(cpf_pkg::CSR_SYNC_FIRST, 8'($urandom));
      write_sync(cpf_pkg::CSR_SYNC_SECOND, 8'($urandom));
      send_data(8'h22);
      send_data(8'h33);
      send_header(8'h50, 8'h60, 16'h0000);
      drain_frames();
   endtask

   task automatic test_random_traffic();
      int send_pcts[3];
      int recv_pcts[3];
      int goal;
      send_pcts = '{9, 74, 0};
      recv_pcts = '{74, 9, 0};
      for (int phase = 0; phase < 3; phase++) begin
         write_sync(cpf_pkg::CSR_SYNC_FIRST, 8'($urandom));
         write_sync(cpf_pkg::CSR_SYNC_SECOND, 8'($urandom));
         send_idle_pct = send_pcts[phase];
         recv_idle_pct = recv_pcts[phase];
         goal = framed_beats + RANDOM_BEATS_PER_PHASE;
         while (framed_beats < goal) send_random_packet();
      end
      drain_frames();
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_op             = cpf_pkg::OP_HEADER;
      req_pid_one        = 8'h00;
      req_pid_two        = 8'h00;
      req_payload_length = 16'h0000;
      req_payload_byte   = 8'h00;
      rsp_stall          = 1'b0;
      csr_write_enable   = 1'b0;
      csr_index          = cpf_pkg::CSR_SYNC_FIRST;
      csr_write_data     = 8'h00;
      model_sync_first   = cpf_pkg::SYNC_FIRST_RESET;
      model_sync_second  = cpf_pkg::SYNC_SECOND_RESET;
      model_remaining    = 16'd0;
      model_sum          = 16'd0;
      model_in_packet    = 1'b0;
      send_idle_pct      = 9;
      recv_idle_pct      = 74;
      errors             = 0;
      beats_sent         = 0;
      framed_beats       = 0;
      bytes_checked      = 0;
      packets_started    = 0;
      sync_writes        = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_data_and_empty_packet();
      test_field_extremes_and_restart();
      test_sync_registers();
      test_random_traffic();
      drain_frames();

      $display("tb: %0d req beats sent, %0d framed bytes checked over %0d packets",
               beats_sent, bytes_checked, packets_started);
      $display("tb: three gap/stall mixes, %0d sync writes, restarts and idle data beats",
               sync_writes);
      if (errors == 0 && frame_bytes.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb: FAIL");
      $finish;
   end

endmodule
